### design/dsil_pkg.sv
// Shared types and codes for the digest set insert/lookup block.
package dsil_pkg;

	localparam int DIGEST_W = 64;

	// Function codes carried on the func field.
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// One queued transaction.
	typedef struct packed {
		logic                func;
		logic [DIGEST_W-1:0] digest_high;
		logic [DIGEST_W-1:0] digest_low;
	} item_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} back_state_t;

	// Back-end status seen by the top level.
	typedef struct packed {
		logic clearing;
		logic busy;
	} back_stat_t;

endpackage

### design/dsil_front.sv
// Front end: accepts transactions, extracts the bucket index, queues them.
module dsil_front #(
	parameter int BKT_W = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dsil_pkg::item_t               in_item,
	output logic                          q_valid,
	input  logic                          q_pop,
	output dsil_pkg::item_t               q_item,
	output logic [BKT_W-1:0]              q_bkt
);

	dsil_pkg::item_t    item_q [2];
	logic [BKT_W-1:0]   bkt_q  [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = item_q[rd_ptr_q];
	assign q_bkt    = bkt_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// Payload slots, no reset. Bucket = top hex digits of the digest.
	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= in_item;
			bkt_q[wr_ptr_q]  <= in_item.digest_high[dsil_pkg::DIGEST_W-1 -: BKT_W];
		end
	end

endmodule

### design/dsil_back.sv
// Back end: bucket scan sequencer, fill-count and entry memories, result register.
module dsil_back #(
	parameter int INDEX_DIGITS = 3,
	parameter int WAYS         = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  dsil_pkg::item_t                q_item,
	input  logic [4*INDEX_DIGITS-1:0]      q_bkt,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic                           bucket_full,
	output dsil_pkg::back_stat_t           stat
);

	localparam int BKT_W   = 4 * INDEX_DIGITS;
	localparam int BUCKETS = 1 << BKT_W;
	localparam int DEPTH   = BUCKETS * WAYS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(WAYS + 1);
	localparam int ENT_W   = 2 * dsil_pkg::DIGEST_W;

	// Fill count per bucket; slots fill in order and never empty.
	logic [CNT_W-1:0]  cnt_mem [BUCKETS];
	logic [ENT_W-1:0]  ent_mem [DEPTH];

	dsil_pkg::back_state_t state_q, state_d;

	logic [BKT_W-1:0]  clr_idx_q;
	logic [CNT_W-1:0]  way_q;
	logic              found_acc_q;
	dsil_pkg::item_t   cur_q;
	logic [BKT_W-1:0]  cur_bkt_q;
	logic [CNT_W-1:0]  cnt_rd_q;
	logic [ENT_W-1:0]  ent_rd_q;
	logic              out_valid_q;
	logic              found_q;
	logic              full_q;

	logic              last_way;
	logic              fire;
	logic              is_add;
	logic              bkt_full;
	logic              do_insert;
	logic              hit;
	logic [BKT_W-1:0]  cnt_raddr;
	logic [ADDR_W-1:0] ent_raddr;
	logic [ADDR_W-1:0] ent_waddr;
	logic              cnt_we;
	logic [BKT_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;

	assign last_way  = (way_q == CNT_W'(WAYS - 1));
	assign is_add    = (cur_q.func == dsil_pkg::FUNC_ADD);
	assign bkt_full  = (cnt_rd_q == CNT_W'(WAYS));
	assign do_insert = is_add && !found_acc_q && !bkt_full;
	assign hit       = (way_q < cnt_rd_q)
		&& (ent_rd_q == {cur_q.digest_high, cur_q.digest_low});
	assign ent_waddr = ADDR_W'(cur_bkt_q) * ADDR_W'(WAYS) + ADDR_W'(cnt_rd_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dsil_pkg::ST_CLEAR: begin
				if (clr_idx_q == {BKT_W{1'b1}})
					state_d = dsil_pkg::ST_IDLE;
			end
			dsil_pkg::ST_IDLE: begin
				if (q_valid)
					state_d = dsil_pkg::ST_SCAN;
			end
			dsil_pkg::ST_SCAN: begin
				if (last_way)
					state_d = dsil_pkg::ST_FINISH;
			end
			dsil_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall)
					state_d = dsil_pkg::ST_IDLE;
			end
			default: state_d = dsil_pkg::ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop     = 1'b0;
		fire      = 1'b0;
		cnt_raddr = cur_bkt_q;
		ent_raddr = ADDR_W'(cur_bkt_q) * ADDR_W'(WAYS) + ADDR_W'(way_q);
		cnt_we    = 1'b0;
		cnt_waddr = cur_bkt_q;
		cnt_wdata = cnt_rd_q + CNT_W'(1);
		case (state_q)
			dsil_pkg::ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
				cnt_wdata = '0;
			end
			dsil_pkg::ST_IDLE: begin
				q_pop     = q_valid;
				cnt_raddr = q_bkt;
				ent_raddr = ADDR_W'(q_bkt) * ADDR_W'(WAYS);
			end
			dsil_pkg::ST_SCAN: begin
				if (!last_way)
					ent_raddr = ADDR_W'(cur_bkt_q) * ADDR_W'(WAYS)
						+ ADDR_W'(way_q + CNT_W'(1));
			end
			dsil_pkg::ST_FINISH: begin
				fire   = !out_valid_q || !out_stall;
				cnt_we = fire && do_insert;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Memories, registered reads
	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (fire && do_insert)
			ent_mem[ent_waddr] <= {cur_q.digest_high, cur_q.digest_low};
		ent_rd_q <= ent_mem[ent_raddr];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsil_pkg::ST_CLEAR;
			clr_idx_q   <= '0;
			way_q       <= '0;
			found_acc_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dsil_pkg::ST_CLEAR)
				clr_idx_q <= clr_idx_q + BKT_W'(1);
			if (q_pop) begin
				way_q       <= '0;
				found_acc_q <= 1'b0;
			end else if (state_q == dsil_pkg::ST_SCAN) begin
				found_acc_q <= found_acc_q | hit;
				if (!last_way)
					way_q <= way_q + CNT_W'(1);
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_item;
			cur_bkt_q <= q_bkt;
		end
		if (fire) begin
			found_q <= found_acc_q;
			full_q  <= is_add && !found_acc_q && bkt_full;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign bucket_full   = full_q;
	assign stat.clearing = (state_q == dsil_pkg::ST_CLEAR);
	assign stat.busy     = (state_q == dsil_pkg::ST_SCAN) || (state_q == dsil_pkg::ST_FINISH);

endmodule

### design/digest_set_insert_lookup.sv
// Digest set insert/lookup top level: front queue plus bucket-scan back end.
// Scheduling: the back end takes one transaction at a time, set by the one-way-per-cycle
//   bucket scan on the single-read-port entry memory, plus a dequeue and a finish state.
// Result path: queue, dequeue, bucket scan and finish state, then the registered result.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the per-bucket fill
//   counts of all 16^INDEX_DIGITS buckets (4096 at default), during which transactions queue up only.
module digest_set_insert_lookup #(
	parameter int INDEX_DIGITS = 3,
	parameter int WAYS         = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] digest_high,
	input  logic [63:0] digest_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic        bucket_full
);

	localparam int BKT_W = 4 * INDEX_DIGITS;

	dsil_pkg::item_t      in_item;
	dsil_pkg::item_t      q_item;
	logic                 q_valid;
	logic                 q_pop;
	logic [BKT_W-1:0]     q_bkt;
	dsil_pkg::back_stat_t stat;

	assign in_item.func        = func;
	assign in_item.digest_high = digest_high;
	assign in_item.digest_low  = digest_low;

	// Front: two-entry queue, bucket index extracted on the way in.
	dsil_front #(
		.BKT_W(BKT_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.q_bkt   (q_bkt)
	);

	// Back: reads the bucket fill count and scans its ways one per cycle,
	// then inserts into the next free slot (adds of new digests to a non-full bucket only) and registers the result.
	dsil_back #(
		.INDEX_DIGITS(INDEX_DIGITS),
		.WAYS        (WAYS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item),
		.q_bkt      (q_bkt),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.bucket_full(bucket_full),
		.stat       (stat)
	);

	// Nothing leaves the queue while fill counts are being cleared.
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !q_pop)
		else $error("queue popped during clearing pass");

	// A pop only happens with a queued transaction, and starts a busy scan.
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue underflow");

	a_pop_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> stat.busy && !q_pop)
		else $error("back end did not take one transaction at a time");

	// A full-bucket flag never comes with a hit.
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && bucket_full))
		else $error("found and bucket_full both set");

endmodule
